// ===== hdl/kcdt_pkg.sv =====
// Package for the keyed cooldown timer table: shared types, codes and sizes.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package kcdt_pkg;

  localparam int TableEntriesDef = 64;
  localparam int InDataW         = 136;
  localparam int OutDataW        = 40;
  localparam logic [31:0] MaxCooldownRst = 32'd3600000;

  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_MARK   = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;
  localparam logic [1:0] REQ_FILTER = 2'd3;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_LOGIN = 2'd1;

  // Classified request as handed from the front to the back.
  typedef struct packed {
    logic [1:0]  req;
    logic [31:0] elapsed;
    logic [31:0] id;
    logic        kind;     // 0 login, 1 any other action
    logic        key_ok;   // id nonzero and action not none
    logic [31:0] cooldown;
    logic        start;
    logic [31:0] limit;
  } cmd_t;

  typedef struct packed {
    logic        valid;
    logic        kind;
    logic [31:0] key;
    logic [31:0] remain;
  } entry_t;

endpackage

// ===== hdl/kcdt_front.sv =====
// Front end: accepts input transfers, decodes them and queues them (two deep).
// Depends on kcdt_pkg.
`timescale 1ns / 1ps
module kcdt_front import kcdt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [InDataW-1:0] in_tdata,
  input  logic [1:0]         in_tuser,
  output logic               q_valid,
  output cmd_t               q_cmd,
  input  logic               q_pop
);

  cmd_t       q_mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       dec;
  logic       push, pop;

  always_comb begin
    dec.req      = in_tuser;
    dec.elapsed  = in_tdata[31:0];
    dec.id       = in_tdata[63:32];
    dec.kind     = (in_tdata[65:64] != ACT_LOGIN);
    dec.key_ok   = (in_tdata[63:32] != 32'd0) && (in_tdata[65:64] != ACT_NONE);
    dec.cooldown = in_tdata[97:66];
    dec.start    = in_tdata[98];
    dec.limit    = in_tdata[130:99];
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign pop       = q_pop && q_valid;
  assign q_cmd     = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= dec;
    end
  end

endmodule

// ===== hdl/kcdt_back.sv =====
// Back end: timer table memory, scan sequencer, filter pick state, result register.
// Depends on kcdt_pkg.
`timescale 1ns / 1ps
module kcdt_back import kcdt_pkg::*; #(
  parameter int TABLE_ENTRIES = TableEntriesDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [31:0]         max_cooldown,
  input  logic                q_valid,
  input  cmd_t                q_cmd,
  output logic                q_pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] LastCnt = CW'(TABLE_ENTRIES - 1);
  localparam logic [CW-1:0] EndCnt  = CW'(TABLE_ENTRIES);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  entry_t mem [TABLE_ENTRIES];

  logic [1:0]          state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                pend_r, pend_nxt;
  logic [AW-1:0]       idx_r;
  entry_t              rd_data_r;
  cmd_t                cmd_r;
  logic                found_r, found_nxt;
  logic [AW-1:0]       hit_idx_r, hit_idx_nxt;
  logic [31:0]         hit_rem_r, hit_rem_nxt;
  logic                free_r, free_nxt;
  logic [AW-1:0]       free_idx_r, free_idx_nxt;
  logic [31:0]         pick_cnt_r, pick_cnt_nxt;
  logic                pick_stop_r, pick_stop_nxt;
  logic                ovalid_r, ovalid_nxt;
  logic [OutDataW-1:0] odata_r, odata_nxt;

  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;
  logic          re;
  logic          match;
  logic          finish;
  logic [31:0]   bounded, rem, cnt_inc;
  logic          elig, picked, full, stop_e;

  assign match = rd_data_r.valid && (rd_data_r.key == cmd_r.id) &&
                 (rd_data_r.kind == cmd_r.kind);
  assign finish  = (state_r == ST_DONE) && (!ovalid_r || out_tready);
  assign bounded = (cmd_r.cooldown < max_cooldown) ? cmd_r.cooldown : max_cooldown;
  assign rem     = (cmd_r.key_ok && found_r) ? hit_rem_r : 32'd0;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = 1'b0;
    re            = 1'b0;
    we            = 1'b0;
    waddr         = idx_r;
    wdata         = rd_data_r;
    found_nxt     = found_r;
    hit_idx_nxt   = hit_idx_r;
    hit_rem_nxt   = hit_rem_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    pick_cnt_nxt  = pick_cnt_r;
    pick_stop_nxt = pick_stop_r;
    ovalid_nxt    = ovalid_r && !out_tready;
    odata_nxt     = odata_r;
    q_pop         = 1'b0;
    elig          = (rem == 32'd0);
    picked        = 1'b0;
    full          = 1'b0;
    stop_e        = cmd_r.start ? 1'b0 : pick_stop_r;
    cnt_inc       = cmd_r.start ? 32'd1 :
                    ((pick_cnt_r == 32'hFFFF_FFFF) ? pick_cnt_r : pick_cnt_r + 32'd1);

    unique case (state_r)
      ST_CLEAR: begin
        // Invalidate every entry once after reset.
        we    = 1'b1;
        waddr = cnt_r[AW-1:0];
        wdata = '0;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == LastCnt) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cnt_nxt   = '0;
          found_nxt = 1'b0;
          free_nxt  = 1'b0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_r != EndCnt) begin
          re       = 1'b1;
          pend_nxt = 1'b1;
          cnt_nxt  = cnt_r + CW'(1);
        end else if (!pend_r) begin
          state_nxt = ST_DONE;
        end
        if (pend_r) begin
          if (cmd_r.req == REQ_TICK) begin
            if (rd_data_r.valid) begin
              we = 1'b1;
              wdata.valid  = (cmd_r.elapsed < rd_data_r.remain);
              wdata.remain = rd_data_r.remain - cmd_r.elapsed;
            end
          end else begin
            if (match && !found_r) begin
              found_nxt   = 1'b1;
              hit_idx_nxt = idx_r;
              hit_rem_nxt = rd_data_r.remain;
            end
            if (!rd_data_r.valid && !free_r) begin
              free_nxt     = 1'b1;
              free_idx_nxt = idx_r;
            end
          end
        end
      end
      ST_DONE: begin
        wdata.valid  = (bounded != 32'd0);
        wdata.kind   = cmd_r.kind;
        wdata.key    = cmd_r.id;
        wdata.remain = bounded;
        waddr        = found_r ? hit_idx_r : free_idx_r;
        if (finish) begin
          if (cmd_r.req == REQ_MARK && cmd_r.key_ok) begin
            if (found_r || (free_r && bounded != 32'd0)) begin
              we = 1'b1;
            end else if (bounded != 32'd0) begin
              full = 1'b1;
            end
          end
          if (cmd_r.req == REQ_FILTER) begin
            pick_stop_nxt = stop_e;
            if (cmd_r.start) begin
              pick_cnt_nxt = 32'd0;
            end
            if (!stop_e && elig) begin
              picked        = 1'b1;
              pick_cnt_nxt  = cnt_inc;
              pick_stop_nxt = (cnt_inc >= cmd_r.limit);
            end
          end
          ovalid_nxt = 1'b1;
          case (cmd_r.req)
            REQ_QUERY:  odata_nxt = {4'd0, 2'b00, 1'b0, elig, rem};
            REQ_FILTER: odata_nxt = {4'd0, 1'b0, pick_stop_nxt, picked, elig, rem};
            default:    odata_nxt = {4'd0, full, 3'b000, 32'd0};
          endcase
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      free_r      <= 1'b0;
      pick_cnt_r  <= 32'd0;
      pick_stop_r <= 1'b0;
      ovalid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      found_r     <= found_nxt;
      free_r      <= free_nxt;
      pick_cnt_r  <= pick_cnt_nxt;
      pick_stop_r <= pick_stop_nxt;
      ovalid_r    <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_idx_r  <= hit_idx_nxt;
    hit_rem_r  <= hit_rem_nxt;
    free_idx_r <= free_idx_nxt;
    odata_r    <= odata_nxt;
    if (q_pop) begin
      cmd_r <= q_cmd;
    end
    if (re) begin
      rd_data_r <= mem[cnt_r[AW-1:0]];
      idx_r     <= cnt_r[AW-1:0];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

endmodule

// ===== hdl/keyed_cooldown_timer_table_unit.sv =====
// Top level of the keyed cooldown timer table: clamp register, front and back.
// Depends on kcdt_pkg, kcdt_front and kcdt_back.
// Each item is handled by the back end's scan, which reads one table entry per
// cycle through one read port; the back end takes no new item until it is done.
// A two-deep queue and the result register let both sides stall independently.
// Reset: synchronous, active low; then a clearing pass over every table entry,
// during which no item is processed.
`timescale 1ns / 1ps
module keyed_cooldown_timer_table_unit import kcdt_pkg::*; #(
  parameter int TABLE_ENTRIES = TableEntriesDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data,
  input  logic                in_tvalid,
  output logic                in_tready,
  // elapsed_ms[31:0] char_id[63:32] action_kind[65:64] cooldown_ms[97:66]
  // list_start[98] pick_limit[130:99], zero fill above
  input  logic [InDataW-1:0]  in_tdata,
  // req_type[1:0]
  input  logic [1:0]          in_tuser,
  output logic                out_tvalid,
  input  logic                out_tready,
  // remaining_ms[31:0] eligible[32] picked[33] list_done[34] table_full[35]
  output logic [OutDataW-1:0] out_tdata
);

  logic [31:0] max_cd_r;
  logic        q_valid, q_pop;
  cmd_t        q_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_cd_r <= MaxCooldownRst;
    end else if (cfg_valid) begin
      max_cd_r <= cfg_data;
    end
  end

  kcdt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop)
  );

  kcdt_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .max_cooldown (max_cd_r),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata)
  );

endmodule

// ===== hdl/kcdt_checker.sv =====
// Port-level checker for keyed_cooldown_timer_table_unit, with its bind.
// Depends on kcdt_pkg.
`timescale 1ns / 1ps
module kcdt_checker import kcdt_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [OutDataW-1:0] out_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_elig: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[31:0] != 32'd0) |-> !out_tdata[32])
    else $error("eligible with time remaining");

  a_pick: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[33] |-> out_tdata[32] && !out_tdata[35])
    else $error("pick of an ineligible element");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[35] |-> out_tdata[34:0] == 35'd0)
    else $error("full flag with other fields set");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind keyed_cooldown_timer_table_unit kcdt_checker u_kcdt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
